// ===== rtl/q2e_pkg.sv =====
// Package: widths, types and tables for the quaternion to Euler converter
`default_nettype none
package q2e_pkg;
  localparam int QW = 16;
  localparam int VW = 36;
  localparam int AW = 25;
  localparam int SW = 62;
  localparam int TABLE_LEN = 24;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam logic signed [AW-1:0] DEG90 = AW'(90 <<< 16);
  localparam logic signed [VW-1:0] ONE_Q30 = VW'(64'sd1 <<< 30);

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] angle_x_deg;
    logic signed [14:0] angle_y_deg;
    logic signed [15:0] angle_z_deg;
    logic               asin_clamped;
  } euler_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] ang;
  } vec_t;

  function automatic logic signed [AW-1:0] atan_tab(input int i);
    int v;
    case (i)
      0: v = 2949120;  1: v = 1740967;  2: v = 919879;  3: v = 466945;
      4: v = 234379;   5: v = 117266;   6: v = 58666;   7: v = 29335;
      8: v = 14668;    9: v = 7334;     10: v = 3667;   11: v = 1833;
      12: v = 917;     13: v = 458;     14: v = 229;    15: v = 115;
      16: v = 57;      17: v = 29;      18: v = 14;     19: v = 7;
      20: v = 4;       21: v = 2;       22: v = 1;
      default: v = 0;
    endcase
    return AW'(v);
  endfunction

  // Pre-rotation into the right half plane
  function automatic vec_t pre_rot(input logic signed [VW-1:0] y,
                                   input logic signed [VW-1:0] x);
    vec_t v;
    v.x = x; v.y = y; v.ang = '0;
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y; v.y = -x; v.ang = DEG90;
      end else begin
        v.x = -y; v.y = x; v.ang = -DEG90;
      end
    end
    return v;
  endfunction

  function automatic vec_t cordic_step(input vec_t v, input int i);
    vec_t r;
    logic signed [VW-1:0] xs, ys;
    xs = v.x >>> i;
    ys = v.y >>> i;
    if (v.y > 0) begin
      r.x = v.x + ys; r.y = v.y - xs; r.ang = v.ang + atan_tab(i);
    end else begin
      r.x = v.x - ys; r.y = v.y + xs; r.ang = v.ang - atan_tab(i);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] deg_q7(input logic signed [AW-1:0] a,
                                                input logic signed [15:0] lim);
    logic signed [AW:0] t;
    logic signed [AW-9:0] v;
    t = {a[AW-1], a} + (AW+1)'(256);
    v = t[AW:9];
    if (v > lim) v = (AW-8)'(lim);
    if (v < -lim) v = -((AW-8)'(lim));
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/q2e_if.sv =====
// Valid/ready channel interface
`default_nettype none
interface q2e_if #(parameter int W = 1) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/q2e_isqrt.sv =====
// Pipelined integer square root, four result bits per stage
`default_nettype none
module q2e_isqrt (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [q2e_pkg::SW-1:0]   rad,
  output logic      [q2e_pkg::VW-1:0]   root
);
  import q2e_pkg::*;
  localparam int NS = 8;
  localparam int BITS = 32;
  logic [SW-1:0] n_r [NS+1];
  logic [BITS-1:0] q_r [NS+1];

  always_comb begin
    n_r[0] = rad;
    q_r[0] = '0;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [SW-1:0] n_nxt;
    logic [BITS-1:0] q_nxt;
    always_comb begin
      logic [SW:0] tr;
      n_nxt = n_r[s];
      q_nxt = q_r[s];
      for (int k = 0; k < 4; k++) begin
        tr = {1'b0, n_nxt} - (((SW+1)'(q_nxt) << 2 | (SW+1)'(1))
              << (2*(BITS-1-(4*s+k))));
        if (!tr[SW]) begin
          n_nxt = tr[SW-1:0];
          q_nxt = (q_nxt << 1) | BITS'(1);
        end else begin
          q_nxt = q_nxt << 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s+1] <= n_nxt;
        q_r[s+1] <= q_nxt;
      end
    end
  end
  assign root = VW'(q_r[NS]);
endmodule
`default_nettype wire

// ===== rtl/q2e_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2 in degrees Q.16
`default_nettype none
module q2e_cordic #(
  parameter int CORDIC_STAGES = q2e_pkg::DEF_CORDIC_STAGES
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [q2e_pkg::VW-1:0]  y_in,
  input  wire logic [q2e_pkg::VW-1:0]  x_in,
  output logic      [q2e_pkg::AW-1:0]  ang
);
  import q2e_pkg::*;
  localparam int NI = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int NS = (NI + 1) / 2;
  vec_t v_r [NS+1];
  logic zero_r [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= pre_rot(y_in, x_in);
      zero_r[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    vec_t v_nxt;
    always_comb begin
      v_nxt = v_r[s];
      for (int k = 0; k < 2; k++) begin
        if (2*s + k < NI) v_nxt = cordic_step(v_nxt, 2*s + k);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[s+1] <= v_nxt;
        zero_r[s+1] <= zero_r[s];
      end
    end
  end
  assign ang = zero_r[NS] ? '0 : v_r[NS].ang;
endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler_angles.sv =====
// Top level: quaternion to Euler angle converter
// One quaternion enters per cycle while the pipe is not stalled, and the three angles
// are offered in order after the products registered at the accepting edge, the sums,
// the radicand, the square root over eight stages, the CORDIC pre-rotation with two
// iterations per stage, and the output register.
// The whole pipe advances whenever the output register is free or being read,
// so back pressure stalls every stage together and nothing is lost.
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = q2e_pkg::DEF_CORDIC_STAGES
) (
  input wire logic clk,
  input wire logic rst_n,
  q2e_if.sink      in_ch,
  q2e_if.source    out_ch
);
  import q2e_pkg::*;
  localparam int CS = ((CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN);
  localparam int LAT = 3 + 8 + 1 + (CS + 1) / 2;

  logic en;
  logic [LAT-1:0] vld_r;
  euler_t res_r;
  logic out_vld_r;
  quat_t q;

  assign q = in_ch.data;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  // stage 1: squares and cross products
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, yz_r, xw_r, xy_r, zw_r, xz_r, yw_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= q.quat_w * q.quat_w; xx_r <= q.quat_x * q.quat_x;
      yy_r <= q.quat_y * q.quat_y; zz_r <= q.quat_z * q.quat_z;
      yz_r <= q.quat_y * q.quat_z; xw_r <= q.quat_x * q.quat_w;
      xy_r <= q.quat_x * q.quat_y; zw_r <= q.quat_z * q.quat_w;
      xz_r <= q.quat_x * q.quat_z; yw_r <= q.quat_y * q.quat_w;
    end
  end

  // stage 2: sums and asin clamp
  logic signed [VW-1:0] xy_n_r, xx_d_r, zy_n_r, zx_d_r, s_r;
  logic clamp_r;
  always_ff @(posedge clk) begin
    logic signed [VW-1:0] s;
    if (en) begin
      xy_n_r <= (VW'(yz_r) + VW'(xw_r)) <<< 1;
      xx_d_r <= -VW'(xx_r) - VW'(yy_r) + VW'(zz_r) + VW'(ww_r);
      zy_n_r <= (VW'(xy_r) + VW'(zw_r)) <<< 1;
      zx_d_r <= VW'(xx_r) - VW'(yy_r) - VW'(zz_r) + VW'(ww_r);
      s = -((VW'(xz_r) - VW'(yw_r)) <<< 1);
      clamp_r <= (s > ONE_Q30) || (s < -ONE_Q30);
      s_r <= (s > ONE_Q30) ? ONE_Q30 : ((s < -ONE_Q30) ? -ONE_Q30 : s);
    end
  end

  // stage 3: 2^60 - s^2
  logic [SW-1:0] rad_r;
  always_ff @(posedge clk) begin
    logic [30:0] a;
    logic [61:0] sq;
    if (en) begin
      a = s_r[VW-1] ? 31'(-s_r) : 31'(s_r);
      sq = 62'(a) * 62'(a);
      rad_r <= (SW'(1) << 60) - sq;
    end
  end

  // delay lines to line atan2 operands and s up with the root
  localparam int DL = 9;
  logic signed [VW-1:0] dxn_r [DL], dxd_r [DL], dzn_r [DL], dzd_r [DL], ds_r [DL];
  logic dcl_r [DL+1+(CS+1)/2];
  always_ff @(posedge clk) begin
    if (en) begin
      dxn_r[0] <= xy_n_r; dxd_r[0] <= xx_d_r;
      dzn_r[0] <= zy_n_r; dzd_r[0] <= zx_d_r;
      ds_r[0] <= s_r; dcl_r[0] <= clamp_r;
      for (int i = 1; i < DL; i++) begin
        dxn_r[i] <= dxn_r[i-1]; dxd_r[i] <= dxd_r[i-1];
        dzn_r[i] <= dzn_r[i-1]; dzd_r[i] <= dzd_r[i-1];
        ds_r[i] <= ds_r[i-1];
      end
      for (int i = 1; i < DL+1+(CS+1)/2; i++) dcl_r[i] <= dcl_r[i-1];
    end
  end

  logic [VW-1:0] root;
  q2e_isqrt u_sqrt (.clk, .en, .rad(rad_r), .root);

  logic [AW-1:0] ax, ay, az;
  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cx (
    .clk, .en, .y_in(dxn_r[DL-1]), .x_in(dxd_r[DL-1]), .ang(ax));
  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cy (
    .clk, .en, .y_in(ds_r[DL-1]), .x_in(root), .ang(ay));
  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cz (
    .clk, .en, .y_in(dzn_r[DL-1]), .x_in(dzd_r[DL-1]), .ang(az));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
      out_vld_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [15:0] yv;
    if (en) begin
      yv = deg_q7(ay, 16'sd11520);
      res_r.angle_x_deg <= deg_q7(ax, 16'sd23040);
      res_r.angle_y_deg <= yv[14:0];
      res_r.angle_z_deg <= deg_q7(az, 16'sd23040);
      res_r.asin_clamped <= dcl_r[DL+(CS+1)/2];
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data = res_r;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(res_r))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_yrange: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.angle_y_deg <= 15'sd11520) && (res_r.angle_y_deg >= -15'sd11520))
    else $error("asin angle out of range");
`endif
endmodule
`default_nettype wire

// ===== verif/quaternion_to_euler_angles_tb.sv =====
// Testbench: quaternion to Euler angle converter, checked against its own fixed-point predictor
`timescale 1ns / 100ps
`default_nettype none
module quaternion_to_euler_angles_tb;
  import q2e_pkg::*;

  localparam int  STAGES    = DEF_CORDIC_STAGES;
  localparam int  LATENCY   = 3 + (STAGES + 1) / 2 + 1 + 9 + 1;
  localparam int  IDLE_LIM  = 4000;
  localparam int  HOLD_LEN  = 300;
  localparam int  N_RANDOM  = 1950;
  localparam longint ONE30  = 64'sd1 <<< 30;
  localparam longint DEG90Q = 64'sd90 <<< 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  q2e_if #(.W($bits(quat_t)))  quat_ch();
  q2e_if #(.W($bits(euler_t))) euler_ch();

  quaternion_to_euler_angles dut (
    .clk(clk), .rst_n(rst_n), .in_ch(quat_ch), .out_ch(euler_ch)
  );

  always #10 clk = ~clk;

  quat_t  quat_queue[$];
  euler_t euler_expected[$];
  int     n_errors   = 0;
  int     n_accepted = 0;
  int     idle_cnt   = 0;
  int     hold_cnt   = 0;
  bit     hold_done  = 1'b0;
  bit     stim_done  = 1'b0;

  // Idle / stall percentages per phase: none, sender, receiver, both
  int send_idle[4]  = '{0, 75, 0, 36};
  int recv_stall[4] = '{0, 0, 75, 36};

  function automatic int phase_of(int n);
    return (n / 250) % 4;
  endfunction

  function automatic longint angle_q16(longint yv, longint xv);
    longint ang, t, xs, ys;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = DEG90Q;
      end else begin
        xv = -yv; yv = t; ang = -DEG90Q;
      end
    end
    for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv += ys; yv -= xs; ang += longint'(atan_tab(i));
      end else begin
        xv -= ys; yv += xs; ang -= longint'(atan_tab(i));
      end
    end
    return ang;
  endfunction

  function automatic longint to_deg7(longint a, longint lim);
    longint v;
    v = (a + 256) >>> 9;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic euler_t euler_of(quat_t q);
    euler_t e;
    longint w, x, y, z, s, c;
    longint unsigned sq;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    e.asin_clamped = 1'b0;
    e.angle_x_deg = 16'(to_deg7(angle_q16(2 * (y * z + x * w),
                                          -x * x - y * y + z * z + w * w), 23040));
    e.angle_z_deg = 16'(to_deg7(angle_q16(2 * (x * y + z * w),
                                          x * x - y * y - z * z + w * w), 23040));
    s = -2 * (x * z - y * w);
    if (s > ONE30) begin
      s = ONE30; e.asin_clamped = 1'b1;
    end
    if (s < -ONE30) begin
      s = -ONE30; e.asin_clamped = 1'b1;
    end
    sq = longint'(s < 0 ? -s : s);
    sq = sq * sq;
    c = longint'(root64((64'd1 << 60) - sq));
    e.angle_y_deg = 15'(to_deg7(angle_q16(s, c), 11520));
    return e;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    n_errors++;
  endtask

  function automatic quat_t mk(int w, int x, int y, int z);
    quat_t q;
    q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
    return q;
  endfunction

  function automatic quat_t unit_quat(bit gimbal);
    real c[4];
    real n;
    quat_t q;
    n = 0.0;
    while (n < 1.0e-3) begin
      for (int i = 0; i < 4; i++)
        c[i] = (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      if (gimbal) begin
        c[2] = c[0] * (($urandom_range(0, 1) != 0) ? 1.0 : -1.0);
        c[1] = c[1] / 64.0; c[3] = c[3] / 64.0;
      end
      n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    end
    q = mk($rtoi(c[0] / n * 32767.0), $rtoi(c[1] / n * 32767.0),
           $rtoi(c[2] / n * 32767.0), $rtoi(c[3] / n * 32767.0));
    return q;
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      quat_ch.valid <= 1'b0;
      quat_ch.data  <= '0;
    end else if (!quat_ch.valid || quat_ch.ready) begin
      if (quat_queue.size() != 0 &&
          $urandom_range(0, 99) >= send_idle[phase_of(n_accepted)]) begin
        quat_ch.data  <= quat_queue.pop_front();
        quat_ch.valid <= 1'b1;
      end else begin
        quat_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off while requests keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      euler_ch.ready <= 1'b0;
    end else if (!hold_done && n_accepted >= 1100) begin
      euler_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN) hold_done <= 1'b1;
    end else begin
      euler_ch.ready <= $urandom_range(0, 99) >= recv_stall[phase_of(n_accepted)];
    end
  end

  // Monitor
  always @(posedge clk) begin
    euler_t got, want;
    if (rst_n) begin
      if (quat_ch.valid && quat_ch.ready) begin
        euler_expected.push_back(euler_of(quat_t'(quat_ch.data)));
        n_accepted <= n_accepted + 1;
      end
      if (euler_ch.valid && euler_ch.ready) begin
        got = euler_t'(euler_ch.data);
        if (euler_expected.size() == 0) begin
          $display("unexpected result %h", got);
          n_errors++;
        end else begin
          want = euler_expected.pop_front();
          if (got.angle_x_deg !== want.angle_x_deg)
            report("angle_x_deg", 32'(got.angle_x_deg), 32'(want.angle_x_deg));
          if (got.angle_y_deg !== want.angle_y_deg)
            report("angle_y_deg", 32'(got.angle_y_deg), 32'(want.angle_y_deg));
          if (got.angle_z_deg !== want.angle_z_deg)
            report("angle_z_deg", 32'(got.angle_z_deg), 32'(want.angle_z_deg));
          if (got.asin_clamped !== want.asin_clamped)
            report("asin_clamped", 32'(got.asin_clamped), 32'(want.asin_clamped));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready) ||
        stim_done)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIM) begin
      $display("quaternion_to_euler_angles_tb: errors");
      $finish;
    end
  end

  initial begin
    int r;
    // identity, extremes, zero vector, atan2 on the negative axis
    quat_queue.push_back(mk(32767, 0, 0, 0));
    quat_queue.push_back(mk(-32768, 0, 0, 0));
    quat_queue.push_back(mk(0, 0, 0, 0));
    quat_queue.push_back(mk(0, 32767, 0, 0));
    quat_queue.push_back(mk(0, -32768, 0, 0));
    quat_queue.push_back(mk(0, 0, 32767, 0));
    quat_queue.push_back(mk(0, 0, 0, 32767));
    quat_queue.push_back(mk(0, 0, 0, -32768));
    quat_queue.push_back(mk(-32768, -32768, -32768, -32768));
    quat_queue.push_back(mk(32767, 32767, 32767, 32767));
    quat_queue.push_back(mk(-32768, 32767, -32768, 32767));
    // gimbal lock, exact and clamped
    quat_queue.push_back(mk(23170, 0, 23170, 0));
    quat_queue.push_back(mk(23170, 0, -23170, 0));
    quat_queue.push_back(mk(32767, 0, 32767, 0));
    quat_queue.push_back(mk(-32768, 0, 32767, 0));
    quat_queue.push_back(mk(0, 32767, 0, 32767));
    quat_queue.push_back(mk(0, 32767, 0, -32768));
    quat_queue.push_back(mk(23170, 23170, 0, 0));
    quat_queue.push_back(mk(23170, -23170, 0, 0));
    quat_queue.push_back(mk(1, -1, 1, -1));
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        quat_queue.push_back(unit_quat(1'b0));
      else if (r < 75)
        quat_queue.push_back(unit_quat(1'b1));
      else
        quat_queue.push_back(quat_t'({$urandom, $urandom}));
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (quat_queue.size() != 0 || quat_ch.valid || euler_expected.size() != 0)
      @(posedge clk);
    stim_done = 1'b1;
    repeat (2 * LATENCY) @(posedge clk);
    if (n_errors == 0 && euler_expected.size() == 0) begin
      $display("quaternion_to_euler_angles_tb: clean");
    end else begin
      $display("quaternion_to_euler_angles_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/q2e_pkg.sv
rtl/q2e_if.sv
rtl/q2e_isqrt.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler_angles.sv
verif/quaternion_to_euler_angles_tb.sv
